// ===== hw/rtl/sefm_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register indexes and controller commands for the stereo echo FIR mixer.
// No dependencies; every other file of the block imports this package.
package sefm_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int VOICE_W           = 26;
   localparam int MIX_W             = 36;
   localparam int COEF_W            = 8;
   localparam int COEF_COUNT        = 8;
   localparam int COEFS_W           = COEF_W * COEF_COUNT;
   localparam int GAIN_W            = 8;
   localparam int SHIFT_W           = 5;
   localparam int ECHO_SHIFT        = 7;
   localparam int FEEDBACK_SHIFT    = 14;
   localparam int TAP_COUNT_DEFAULT = 8;
   localparam int TAP_WIDE_W        = 4;
   localparam int TAP_PROD_W        = SAMPLE_W + COEF_W;
   localparam int FIR_W             = TAP_PROD_W + 4;
   localparam int FIR_PROD_W        = FIR_W + GAIN_W;
   localparam int MAIN_PROD_W       = VOICE_W + GAIN_W;
   localparam int SUM_W             = FIR_PROD_W + 2;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = COEFS_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIR_COEFFS        = 3'd0,
      CSR_FEEDBACK_GAIN     = 3'd1,
      CSR_ECHO_GAIN_LEFT    = 3'd2,
      CSR_ECHO_GAIN_RIGHT   = 3'd3,
      CSR_MASTER_GAIN_LEFT  = 3'd4,
      CSR_MASTER_GAIN_RIGHT = 3'd5,
      CSR_MUTE_SHIFT        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic fir_step;
      logic scale;
      logic mix;
   } dp_cmd_type;

endpackage

// ===== hw/rtl/sefm_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the stereo echo FIR mixer: request handshake, tap counter and result valid.
// Depends on sefm_pkg for the datapath command struct.
module sefm_ctrl #(
   parameter int TapCount = sefm_pkg::TAP_COUNT_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sefm_pkg::dp_cmd_type         cmd,
   output logic [$clog2(TapCount)-1:0]  tap_sel
);
   import sefm_pkg::*;

   localparam int TapIdxW = $clog2(TapCount);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FIR   = 4'b0010,
      ST_SCALE = 4'b0100,
      ST_MIX   = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [TapIdxW-1:0] tap_ff, tap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               last_tap;
   logic               out_free;

   assign last_tap  = (tap_ff == TapIdxW'(TapCount - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign tap_sel   = tap_ff;

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            tap_in = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_FIR;
            end
         end
         ST_FIR: begin
            cmd.fir_step = 1'b1;
            tap_in       = tap_ff + 1'b1;
            if (last_tap) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_MIX;
         end
         ST_MIX: begin
            if (out_free) begin
               cmd.mix      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/sefm_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the stereo echo FIR mixer: settings registers, stereo delay line,
// shared FIR multiply-accumulate, gain products and result registers. Depends on sefm_pkg.
module sefm_datapath #(
   parameter int TapCount = sefm_pkg::TAP_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sefm_pkg::dp_cmd_type                cmd,
   input  logic [$clog2(TapCount)-1:0]         tap_sel,
   input  logic                                csr_valid,
   input  logic [sefm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sefm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic signed [sefm_pkg::SAMPLE_W-1:0] req_echo_read_left,
   input  logic signed [sefm_pkg::SAMPLE_W-1:0] req_echo_read_right,
   input  logic signed [sefm_pkg::VOICE_W-1:0]  req_voice_echo_left,
   input  logic signed [sefm_pkg::VOICE_W-1:0]  req_voice_echo_right,
   input  logic signed [sefm_pkg::VOICE_W-1:0]  req_voice_main_left,
   input  logic signed [sefm_pkg::VOICE_W-1:0]  req_voice_main_right,
   output logic signed [sefm_pkg::MIX_W-1:0]    rsp_mix_left,
   output logic signed [sefm_pkg::MIX_W-1:0]    rsp_mix_right,
   output logic signed [sefm_pkg::SAMPLE_W-1:0] rsp_echo_write_left,
   output logic signed [sefm_pkg::SAMPLE_W-1:0] rsp_echo_write_right
);
   import sefm_pkg::*;

   localparam int TapIdxW = $clog2(TapCount);

   logic [COEFS_W-1:0]        coeffs_ff;
   logic signed [GAIN_W-1:0]  fb_gain_ff;
   logic signed [GAIN_W-1:0]  echo_gain_l_ff, echo_gain_r_ff;
   logic signed [GAIN_W-1:0]  main_gain_l_ff, main_gain_r_ff;
   logic [SHIFT_W-1:0]        mute_shift_ff;

   logic signed [SAMPLE_W-1:0] hist_l_ff [TapCount];
   logic signed [SAMPLE_W-1:0] hist_r_ff [TapCount];

   logic signed [VOICE_W-1:0] vecho_l_ff, vecho_r_ff, vmain_l_ff, vmain_r_ff;
   logic signed [FIR_W-1:0]   acc_l_ff, acc_r_ff, acc_l_in, acc_r_in;

   logic signed [FIR_PROD_W-1:0]  fb_l_ff, fb_r_ff, eg_l_ff, eg_r_ff;
   logic signed [MAIN_PROD_W-1:0] mg_l_ff, mg_r_ff;

   logic signed [MIX_W-1:0]    mix_l_ff, mix_r_ff;
   logic signed [SAMPLE_W-1:0] ew_l_ff, ew_r_ff;

   logic [TAP_WIDE_W-1:0]     tap_wide;
   logic [TapIdxW-1:0]        tap_pos;
   logic signed [COEF_W-1:0]  coef;
   logic signed [TAP_PROD_W-1:0] prod_l, prod_r;

   logic signed [SUM_W-1:0] mix_sum_l, mix_sum_r, mix_sh_l, mix_sh_r;
   logic signed [SUM_W-1:0] echo_sum_l, echo_sum_r;
   logic signed [SAMPLE_W-1:0] echo_cl_l, echo_cl_r;

   function automatic logic signed [SAMPLE_W-1:0] clamp16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(32767);
      lo = -SUM_W'(32768);
      if (v > hi) begin
         clamp16 = 16'sh7fff;
      end else if (v < lo) begin
         clamp16 = 16'sh8000;
      end else begin
         clamp16 = v[SAMPLE_W-1:0];
      end
   endfunction

   // Tap 0 is the newest sample; tap i is the sample from TapCount-i requests back.
   assign tap_wide = TAP_WIDE_W'(tap_sel);
   assign tap_pos  = (tap_sel == '0) ? '0 : TapIdxW'(TapCount) - tap_sel;
   assign coef     = tap_wide[TAP_WIDE_W-1] ? '0
                   : coeffs_ff[COEF_W*tap_wide[TAP_WIDE_W-2:0] +: COEF_W];
   assign prod_l   = hist_l_ff[tap_pos] * coef;
   assign prod_r   = hist_r_ff[tap_pos] * coef;
   assign acc_l_in = acc_l_ff + FIR_W'(prod_l);
   assign acc_r_in = acc_r_ff + FIR_W'(prod_r);

   assign mix_sum_l = SUM_W'(mg_l_ff) + SUM_W'(eg_l_ff);
   assign mix_sum_r = SUM_W'(mg_r_ff) + SUM_W'(eg_r_ff);
   assign mix_sh_l  = mix_sum_l >>> mute_shift_ff;
   assign mix_sh_r  = mix_sum_r >>> mute_shift_ff;

   assign echo_sum_l = SUM_W'(vecho_l_ff >>> ECHO_SHIFT) + SUM_W'(fb_l_ff >>> FEEDBACK_SHIFT);
   assign echo_sum_r = SUM_W'(vecho_r_ff >>> ECHO_SHIFT) + SUM_W'(fb_r_ff >>> FEEDBACK_SHIFT);
   assign echo_cl_l  = clamp16(echo_sum_l);
   assign echo_cl_r  = clamp16(echo_sum_r);

   always_ff @(posedge clock) begin
      if (reset) begin
         coeffs_ff      <= '0;
         fb_gain_ff     <= '0;
         echo_gain_l_ff <= '0;
         echo_gain_r_ff <= '0;
         main_gain_l_ff <= '0;
         main_gain_r_ff <= '0;
         mute_shift_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIR_COEFFS:        coeffs_ff      <= csr_wdata;
            CSR_FEEDBACK_GAIN:     fb_gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_ECHO_GAIN_LEFT:    echo_gain_l_ff <= csr_wdata[GAIN_W-1:0];
            CSR_ECHO_GAIN_RIGHT:   echo_gain_r_ff <= csr_wdata[GAIN_W-1:0];
            CSR_MASTER_GAIN_LEFT:  main_gain_l_ff <= csr_wdata[GAIN_W-1:0];
            CSR_MASTER_GAIN_RIGHT: main_gain_r_ff <= csr_wdata[GAIN_W-1:0];
            CSR_MUTE_SHIFT:        mute_shift_ff  <= csr_wdata[SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TapCount; i++) begin
            hist_l_ff[i] <= '0;
            hist_r_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         hist_l_ff[0] <= req_echo_read_left;
         hist_r_ff[0] <= req_echo_read_right;
         for (int i = 1; i < TapCount; i++) begin
            hist_l_ff[i] <= hist_l_ff[i-1];
            hist_r_ff[i] <= hist_r_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vecho_l_ff <= req_voice_echo_left;
         vecho_r_ff <= req_voice_echo_right;
         vmain_l_ff <= req_voice_main_left;
         vmain_r_ff <= req_voice_main_right;
         acc_l_ff   <= '0;
         acc_r_ff   <= '0;
      end else if (cmd.fir_step) begin
         acc_l_ff <= acc_l_in;
         acc_r_ff <= acc_r_in;
      end
      if (cmd.scale) begin
         fb_l_ff <= acc_l_ff * fb_gain_ff;
         fb_r_ff <= acc_r_ff * fb_gain_ff;
         eg_l_ff <= acc_l_ff * echo_gain_l_ff;
         eg_r_ff <= acc_r_ff * echo_gain_r_ff;
         mg_l_ff <= vmain_l_ff * main_gain_l_ff;
         mg_r_ff <= vmain_r_ff * main_gain_r_ff;
      end
      if (cmd.mix) begin
         mix_l_ff <= mix_sh_l[MIX_W-1:0];
         mix_r_ff <= mix_sh_r[MIX_W-1:0];
         ew_l_ff  <= echo_cl_l;
         ew_r_ff  <= echo_cl_r;
      end
   end

   assign rsp_mix_left         = mix_l_ff;
   assign rsp_mix_right        = mix_r_ff;
   assign rsp_echo_write_left  = ew_l_ff;
   assign rsp_echo_write_right = ew_r_ff;

endmodule

// ===== hw/rtl/stereo_echo_fir_mixer.sv =====
`timescale 1ns / 1ps
// Top level of the stereo echo FIR mixer: joins the sequencer and the datapath.
// Depends on sefm_pkg, sefm_ctrl and sefm_datapath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  echo reads, voice echo and main sums
//   rsp_      out        rsp_valid / rsp_stall  mix and echo write-back, per side
//   csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A request is accepted only in the idle cycle, which loads it. The FIR state then steps
// through every tap on the multiply-accumulate that each side shares across its taps,
// the scale state forms the gain products and the mix state registers the result. No new
// request is accepted until the mix state has registered the result. The mix cycle waits while
// an earlier result is still stalled, and the request side waits for it in turn.
// Reset is synchronous and clears the delay line and all settings.
module stereo_echo_fir_mixer #(
   parameter int TapCount = sefm_pkg::TAP_COUNT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sefm_pkg::SAMPLE_W-1:0] req_echo_read_left,
   input  logic signed [sefm_pkg::SAMPLE_W-1:0] req_echo_read_right,
   input  logic signed [sefm_pkg::VOICE_W-1:0]  req_voice_echo_left,
   input  logic signed [sefm_pkg::VOICE_W-1:0]  req_voice_echo_right,
   input  logic signed [sefm_pkg::VOICE_W-1:0]  req_voice_main_left,
   input  logic signed [sefm_pkg::VOICE_W-1:0]  req_voice_main_right,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [sefm_pkg::MIX_W-1:0]    rsp_mix_left,
   output logic signed [sefm_pkg::MIX_W-1:0]    rsp_mix_right,
   output logic signed [sefm_pkg::SAMPLE_W-1:0] rsp_echo_write_left,
   output logic signed [sefm_pkg::SAMPLE_W-1:0] rsp_echo_write_right,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sefm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sefm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sefm_pkg::*;

   dp_cmd_type                  cmd;
   logic [$clog2(TapCount)-1:0] tap_sel;

   assign csr_ready = 1'b1;

   sefm_ctrl #(
      .TapCount(TapCount)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .tap_sel   (tap_sel)
   );

   sefm_datapath #(
      .TapCount(TapCount)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .tap_sel              (tap_sel),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_echo_read_left   (req_echo_read_left),
      .req_echo_read_right  (req_echo_read_right),
      .req_voice_echo_left  (req_voice_echo_left),
      .req_voice_echo_right (req_voice_echo_right),
      .req_voice_main_left  (req_voice_main_left),
      .req_voice_main_right (req_voice_main_right),
      .rsp_mix_left         (rsp_mix_left),
      .rsp_mix_right        (rsp_mix_right),
      .rsp_echo_write_left  (rsp_echo_write_left),
      .rsp_echo_write_right (rsp_echo_write_right)
   );

endmodule

// ===== sim/stereo_echo_fir_mixer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stereo_echo_fir_mixer: directed and random requests under
// varied register settings and handshake pressure, checked against an in-bench predictor.
// Depends on sefm_pkg and the stereo_echo_fir_mixer RTL.
module stereo_echo_fir_mixer_test;
   import sefm_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int DRAIN_CYCLES = TAP_COUNT_DEFAULT + 3 + 4;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_REQUESTS = 72;

   typedef struct {
      logic signed [SAMPLE_W-1:0] echo_read_left;
      logic signed [SAMPLE_W-1:0] echo_read_right;
      logic signed [VOICE_W-1:0]  voice_echo_left;
      logic signed [VOICE_W-1:0]  voice_echo_right;
      logic signed [VOICE_W-1:0]  voice_main_left;
      logic signed [VOICE_W-1:0]  voice_main_right;
   } mix_request_type;

   typedef struct {
      logic signed [MIX_W-1:0]    mix_left;
      logic signed [MIX_W-1:0]    mix_right;
      logic signed [SAMPLE_W-1:0] echo_write_left;
      logic signed [SAMPLE_W-1:0] echo_write_right;
   } mix_result_type;

   typedef struct {
      logic [COEFS_W-1:0] coeffs;
      logic [GAIN_W-1:0]  feedback;
      logic [GAIN_W-1:0]  echo_left;
      logic [GAIN_W-1:0]  echo_right;
      logic [GAIN_W-1:0]  master_left;
      logic [GAIN_W-1:0]  master_right;
      logic [SHIFT_W-1:0] shift;
   } mixer_setting_type;

   class echo_mix_scoreboard;
      logic signed [SAMPLE_W-1:0] line_left[TAP_COUNT_DEFAULT];
      logic signed [SAMPLE_W-1:0] line_right[TAP_COUNT_DEFAULT];
      int unsigned next_slot;
      logic [COEFS_W-1:0] coeffs;
      logic signed [GAIN_W-1:0] feedback;
      logic signed [GAIN_W-1:0] echo_left;
      logic signed [GAIN_W-1:0] echo_right;
      logic signed [GAIN_W-1:0] master_left;
      logic signed [GAIN_W-1:0] master_right;
      logic [SHIFT_W-1:0] shift;
      mix_result_type expected_mix_q[$];
      int errors;
      int requests;
      int results;

      function new();
         foreach (line_left[k]) begin
            line_left[k] = '0;
            line_right[k] = '0;
         end
         next_slot = 0;
         coeffs = '0;
         feedback = '0;
         echo_left = '0;
         echo_right = '0;
         master_left = '0;
         master_right = '0;
         shift = '0;
         errors = 0;
         requests = 0;
         results = 0;
      endfunction

      task report_mismatch(input string what);
         $display("%0t ns: MISMATCH %s", $time, what);
         errors++;
      endtask

      function int pending();
         return expected_mix_q.size();
      endfunction

      function longint clamp_sample(input longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function void write_setting(input logic [CSR_INDEX_W-1:0] index,
                                  input logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_FIR_COEFFS:        coeffs = data;
            CSR_FEEDBACK_GAIN:     feedback = data[GAIN_W-1:0];
            CSR_ECHO_GAIN_LEFT:    echo_left = data[GAIN_W-1:0];
            CSR_ECHO_GAIN_RIGHT:   echo_right = data[GAIN_W-1:0];
            CSR_MASTER_GAIN_LEFT:  master_left = data[GAIN_W-1:0];
            CSR_MASTER_GAIN_RIGHT: master_right = data[GAIN_W-1:0];
            CSR_MUTE_SHIFT:        shift = data[SHIFT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(input mix_request_type r);
         longint fir_left;
         longint fir_right;
         longint coef;
         longint sum_left;
         longint sum_right;
         int unsigned slot;
         int unsigned tap;
         int unsigned idx;
         mix_result_type e;
         slot = next_slot;
         line_left[slot] = r.echo_read_left;
         line_right[slot] = r.echo_read_right;
         fir_left = 0;
         fir_right = 0;
         for (tap = 0; tap < TAP_COUNT_DEFAULT; tap++) begin
            idx = (slot + tap) % TAP_COUNT_DEFAULT;
            if (tap < COEF_COUNT) coef = longint'($signed(coeffs[COEF_W*tap +: COEF_W]));
            else coef = 0;
            fir_left += longint'(line_left[idx]) * coef;
            fir_right += longint'(line_right[idx]) * coef;
         end
         next_slot = (slot + 1) % TAP_COUNT_DEFAULT;
         sum_left = clamp_sample((longint'(r.voice_echo_left) >>> ECHO_SHIFT)
                                 + ((fir_left * longint'(feedback)) >>> FEEDBACK_SHIFT));
         sum_right = clamp_sample((longint'(r.voice_echo_right) >>> ECHO_SHIFT)
                                  + ((fir_right * longint'(feedback)) >>> FEEDBACK_SHIFT));
         e.echo_write_left = sum_left[SAMPLE_W-1:0];
         e.echo_write_right = sum_right[SAMPLE_W-1:0];
         sum_left = (longint'(r.voice_main_left) * longint'(master_left)
                     + fir_left * longint'(echo_left)) >>> shift;
         sum_right = (longint'(r.voice_main_right) * longint'(master_right)
                      + fir_right * longint'(echo_right)) >>> shift;
         e.mix_left = sum_left[MIX_W-1:0];
         e.mix_right = sum_right[MIX_W-1:0];
         expected_mix_q.push_back(e);
         requests++;
      endfunction

      task check_result(input mix_result_type got);
         mix_result_type e;
         results++;
         if (expected_mix_q.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            e = expected_mix_q.pop_front();
            if (got.mix_left !== e.mix_left)
               report_mismatch($sformatf("mix_left got %0d expected %0d",
                                         got.mix_left, e.mix_left));
            if (got.mix_right !== e.mix_right)
               report_mismatch($sformatf("mix_right got %0d expected %0d",
                                         got.mix_right, e.mix_right));
            if (got.echo_write_left !== e.echo_write_left)
               report_mismatch($sformatf("echo_write_left got %0d expected %0d",
                                         got.echo_write_left, e.echo_write_left));
            if (got.echo_write_right !== e.echo_write_right)
               report_mismatch($sformatf("echo_write_right got %0d expected %0d",
                                         got.echo_write_right, e.echo_write_right));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_echo_read_left = '0;
   logic signed [SAMPLE_W-1:0] req_echo_read_right = '0;
   logic signed [VOICE_W-1:0] req_voice_echo_left = '0;
   logic signed [VOICE_W-1:0] req_voice_echo_right = '0;
   logic signed [VOICE_W-1:0] req_voice_main_left = '0;
   logic signed [VOICE_W-1:0] req_voice_main_right = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [MIX_W-1:0] rsp_mix_left;
   logic signed [MIX_W-1:0] rsp_mix_right;
   logic signed [SAMPLE_W-1:0] rsp_echo_write_left;
   logic signed [SAMPLE_W-1:0] rsp_echo_write_right;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int settings_loaded = 0;
   echo_mix_scoreboard board;

   stereo_echo_fir_mixer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_echo_read_left(req_echo_read_left),
      .req_echo_read_right(req_echo_read_right),
      .req_voice_echo_left(req_voice_echo_left),
      .req_voice_echo_right(req_voice_echo_right),
      .req_voice_main_left(req_voice_main_left),
      .req_voice_main_right(req_voice_main_right),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_mix_left(rsp_mix_left),
      .rsp_mix_right(rsp_mix_right),
      .rsp_echo_write_left(rsp_echo_write_left),
      .rsp_echo_write_right(rsp_echo_write_right),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      board = new();
      forever #4 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("Timed out with %0d results outstanding.", board.pending());
      $display("stereo_echo_fir_mixer_test failed");
      $finish;
   end

   always @(posedge clock) begin
      mix_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.mix_left = rsp_mix_left;
         got.mix_right = rsp_mix_right;
         got.echo_write_left = rsp_echo_write_left;
         got.echo_write_right = rsp_echo_write_right;
         board.check_result(got);
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic mix_request_type make_request(
      input logic signed [SAMPLE_W-1:0] rl, input logic signed [SAMPLE_W-1:0] rr,
      input logic signed [VOICE_W-1:0] vel, input logic signed [VOICE_W-1:0] ver,
      input logic signed [VOICE_W-1:0] vml, input logic signed [VOICE_W-1:0] vmr);
      mix_request_type r;
      r.echo_read_left = rl;
      r.echo_read_right = rr;
      r.voice_echo_left = vel;
      r.voice_echo_right = ver;
      r.voice_main_left = vml;
      r.voice_main_right = vmr;
      return r;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic signed [7:0] tiny;
      tiny = 8'($urandom);
      case ($urandom_range(7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return SAMPLE_W'(tiny);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [VOICE_W-1:0] random_voice();
      logic signed [21:0] modest;
      modest = 22'($urandom);
      case ($urandom_range(7))
         0: return {1'b0, {(VOICE_W-1){1'b1}}};
         1: return {1'b1, {(VOICE_W-1){1'b0}}};
         2, 3: return VOICE_W'(modest);
         default: return VOICE_W'($urandom);
      endcase
   endfunction

   function automatic mix_request_type random_request();
      return make_request(random_sample(), random_sample(), random_voice(),
                          random_voice(), random_voice(), random_voice());
   endfunction

   function automatic logic [CSR_DATA_W-1:0] with_noise(input logic [CSR_DATA_W-1:0] v,
                                                         input int w);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] noise;
      mask = (64'h1 << w) - 64'h1;
      noise = {$urandom, $urandom};
      return (noise & ~mask) | (v & mask);
   endfunction

   function automatic mixer_setting_type random_setting();
      mixer_setting_type s;
      s.coeffs = {$urandom, $urandom};
      s.feedback = GAIN_W'($urandom);
      s.echo_left = GAIN_W'($urandom);
      s.echo_right = GAIN_W'($urandom);
      s.master_left = GAIN_W'($urandom);
      s.master_right = GAIN_W'($urandom);
      s.shift = SHIFT_W'(($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(6));
      return s;
   endfunction

   function automatic mixer_setting_type uniform_setting(input logic [GAIN_W-1:0] g,
                                                         input logic [SHIFT_W-1:0] sh);
      mixer_setting_type s;
      s.coeffs = {COEF_COUNT{g}};
      s.feedback = g;
      s.echo_left = g;
      s.echo_right = g;
      s.master_left = g;
      s.master_right = g;
      s.shift = sh;
      return s;
   endfunction

   task automatic send_request(input mix_request_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_echo_read_left <= r.echo_read_left;
      req_echo_read_right <= r.echo_read_right;
      req_voice_echo_left <= r.voice_echo_left;
      req_voice_echo_right <= r.voice_echo_right;
      req_voice_main_left <= r.voice_main_left;
      req_voice_main_right <= r.voice_main_right;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic wait_for_drain(input int extra_cycles);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_setting(index, data);
   endtask

   task automatic load_settings(input mixer_setting_type s);
      write_register(CSR_FIR_COEFFS, s.coeffs);
      write_register(CSR_FEEDBACK_GAIN, with_noise(CSR_DATA_W'(s.feedback), GAIN_W));
      write_register(CSR_ECHO_GAIN_LEFT, with_noise(CSR_DATA_W'(s.echo_left), GAIN_W));
      write_register(CSR_ECHO_GAIN_RIGHT, with_noise(CSR_DATA_W'(s.echo_right), GAIN_W));
      write_register(CSR_MASTER_GAIN_LEFT, with_noise(CSR_DATA_W'(s.master_left), GAIN_W));
      write_register(CSR_MASTER_GAIN_RIGHT,
                     with_noise(CSR_DATA_W'(s.master_right), GAIN_W));
      write_register(CSR_MUTE_SHIFT, with_noise(CSR_DATA_W'(s.shift), SHIFT_W));
      write_register(CSR_SPARE_INDEX, {$urandom, $urandom});
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   initial begin
      mixer_setting_type s;
      int phase;
      int n;
      int guard;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_request(make_request('0, '0, '0, '0, '0, '0));
      send_request(make_request(16'sh7FFF, 16'sh7FFF, 26'sh1FFFFFF, 26'sh1FFFFFF,
                                26'sh1FFFFFF, 26'sh1FFFFFF));
      send_request(make_request(16'sh8000, 16'sh8000, 26'sh2000000, 26'sh2000000,
                                26'sh2000000, 26'sh2000000));
      wait_for_drain(DRAIN_CYCLES);

      s.coeffs = 64'h80_7F_01_FF_40_C0_02_FE;
      s.feedback = 8'h7F;
      s.echo_left = 8'h80;
      s.echo_right = 8'h7F;
      s.master_left = 8'h7F;
      s.master_right = 8'h80;
      s.shift = '0;
      load_settings(s);
      send_request(make_request(16'sh7FFF, 16'sh8000, 26'sh1FFFFFF, 26'sh2000000,
                                26'sh2000000, 26'sh1FFFFFF));
      send_request(make_request(-16'sd1, 16'sd1, -26'sd1, 26'sd1, -26'sd1, 26'sd1));
      send_request(make_request(16'sd1, -16'sd1, 26'sd127, -26'sd128, 26'sd128, -26'sd129));
      send_request(make_request(16'sh5555, 16'shAAAA, 26'sh1555555, 26'sh2AAAAAA,
                                26'sh2AAAAAA, 26'sh1555555));
      wait_for_drain(DRAIN_CYCLES);

      load_settings(uniform_setting(8'h80, 5'd0));
      for (n = 0; n < TAP_COUNT_DEFAULT + 1; n++)
         send_request(make_request(16'sh8000, 16'sh8000, 26'sh2000000, 26'sh1FFFFFF,
                                   26'sh2000000, 26'sh1FFFFFF));

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain(DRAIN_CYCLES);
         case (phase)
            0: s = uniform_setting(8'h7F, 5'd0);
            1: s = uniform_setting(8'h80, 5'd31);
            default: s = random_setting();
         endcase
         load_settings(s);
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 81; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 81; end
            default: begin req_idle_pct = 25; rsp_stall_pct = 25; end
         endcase
         for (n = 0; n < PHASE_REQUESTS; n++) begin
            if (phase == 3 && n == PHASE_REQUESTS / 2) wait_for_drain(0);
            send_request(random_request());
         end
      end
      req_valid <= 1'b0;

      guard = 0;
      while (board.pending() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.pending() != 0)
         board.report_mismatch($sformatf("%0d expected results never arrived",
                                         board.pending()));

      $display("Sent %0d requests and checked %0d results across %0d register settings,",
               board.requests, board.results, settings_loaded);
      $display("with sender idling and receiver stalling from none up to 81 percent.");
      if (board.errors == 0) begin
         $display("stereo_echo_fir_mixer_test passed");
      end else begin
         $display("Found %0d mismatches.", board.errors);
         $display("stereo_echo_fir_mixer_test failed");
      end
      $finish;
   end

endmodule
